// ===== src/bezier_segment_tessellator_defines.svh =====
// Assertion macros for the bezier segment tessellator.
// Taken by the top level; expects clk and arst_n in scope.
`ifndef BEZIER_SEGMENT_TESSELLATOR_DEFINES_SVH
`define BEZIER_SEGMENT_TESSELLATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BST_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define BST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/bst_pkg.sv =====
// Shared types and constants for the bezier segment tessellator.
// Used by the controller, the datapath, the step divider and the top level.
package bst_pkg;

	localparam int T_FRAC = 16;
	localparam int T_BITS = 17;
	localparam logic [T_BITS-1:0] T_ONE = 17'h10000;

	localparam int STEPS_W   = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS      = 1'b1;

	localparam logic KIND_CUBIC = 1'b0;
	localparam logic KIND_QUAD  = 1'b1;

	localparam logic [2:0] OP_LAST_CUBIC = 3'd5;
	localparam logic [2:0] OP_LAST_QUAD  = 3'd2;

	typedef struct packed {
		logic       load_cp;
		logic       div_start;
		logic       t_init;
		logic       t_adv;
		logic       load_w;
		logic       mul;
		logic       add;
		logic [1:0] k;
		logic       axis_done;
		logic       out_load;
		logic       last;
	} bst_cmd_t;

	typedef struct packed {
		logic t_one;
	} bst_sts_t;

	// operand slot of each interpolation in the de Casteljau sequence
	function automatic logic [1:0] op_k(input logic kind, input logic [2:0] idx);
		logic [1:0] k;
		k = 2'd0;
		if (kind == KIND_QUAD) begin
			case (idx)
				3'd1:    k = 2'd1;
				default: k = 2'd0;
			endcase
		end else begin
			case (idx)
				3'd1:    k = 2'd1;
				3'd2:    k = 2'd2;
				3'd4:    k = 2'd1;
				default: k = 2'd0;
			endcase
		end
		return k;
	endfunction

endpackage

// ===== src/bst_div.sv =====
// Restoring divider for one unit of t by the step count: quotient and remainder.
// Depends on bst_pkg.
module bst_div #(
	parameter int SW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [SW-1:0]              n,
	output logic                       done,
	output logic [bst_pkg::T_BITS-1:0] q,
	output logic [SW-1:0]              r
);

	localparam int CNT_W = $clog2(bst_pkg::T_BITS);

	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [SW-1:0]              rem_q;
	logic [bst_pkg::T_BITS-1:0] quo_q;
	logic                       dbit;
	logic [SW:0]                trial;
	logic                       fits;

	assign dbit  = (cnt_q == CNT_W'(bst_pkg::T_FRAC));
	assign trial = {rem_q, dbit};
	assign fits  = (trial >= {1'b0, n});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(bst_pkg::T_FRAC);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? SW'(trial - {1'b0, n}) : SW'(trial);
			quo_q <= {quo_q[bst_pkg::T_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign q    = quo_q;
	assign r    = rem_q;

endmodule

// ===== src/bst_ctrl.sv =====
// Controller state machine for the tessellator: sequences points, axes and
// interpolations and owns the result handshake. Depends on bst_pkg.
module bst_ctrl #(
	parameter int SW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  logic              kind,
	input  logic [SW-1:0]     n_eff,
	input  logic              div_done,
	output bst_pkg::bst_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_TSTEP = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_AXIS  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam logic [1:0] AXIS_Z = 2'd2;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [SW-1:0] step_q;
	logic [2:0]    op_q;
	logic [1:0]    axis_q;
	logic          out_valid_q;
	logic          out_free;
	logic          is_last;
	logic [2:0]    last_op;

	assign out_free = !out_valid_q || out_ready;
	assign is_last  = (step_q == n_eff);
	assign last_op  = (kind == bst_pkg::KIND_QUAD) ? bst_pkg::OP_LAST_QUAD
	                                               : bst_pkg::OP_LAST_CUBIC;

	always_comb begin
		cmd      = '0;
		cmd.k    = bst_pkg::op_k(kind, op_q);
		cmd.last = is_last;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_cp   = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					cmd.t_init = 1'b1;
					state_d    = S_TSTEP;
				end
			end
			S_TSTEP: begin
				cmd.t_adv = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load_w = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = (op_q == last_op) ? S_AXIS : S_MUL;
			end
			S_AXIS: begin
				cmd.axis_done = 1'b1;
				state_d       = (axis_q == AXIS_Z) ? S_OUT : S_LOAD;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = is_last ? S_IDLE : S_TSTEP;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			op_q        <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.t_init) begin
				step_q <= '0;
			end
			if (cmd.t_adv) begin
				step_q <= step_q + 1'b1;
				axis_q <= '0;
			end
			if (cmd.load_w) begin
				op_q <= '0;
			end
			if (cmd.add) begin
				op_q <= op_q + 1'b1;
			end
			if (cmd.axis_done) begin
				axis_q <= axis_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/bst_dp.sv =====
// Datapath for the tessellator: control point store, t stepping, shared
// interpolation unit, saturation and result register. Depends on bst_pkg.
module bst_dp #(
	parameter int C       = 32,
	parameter int SW      = 7,
	parameter int IN_TDW  = 384,
	parameter int OUT_TDW = 96
) (
	input  logic                       clk,
	input  logic [IN_TDW-1:0]          in_data,
	input  logic                       kind,
	input  logic [SW-1:0]              n_eff,
	input  logic [bst_pkg::T_BITS-1:0] q,
	input  logic [SW-1:0]              r,
	input  bst_pkg::bst_cmd_t          cmd,
	output bst_pkg::bst_sts_t          sts,
	output logic [OUT_TDW-1:0]         out_data,
	output logic                       out_last
);

	localparam int CW = C + 1;
	localparam int DW = CW + 1;
	localparam int PW = DW + bst_pkg::T_BITS + 1;

	logic signed [CW-1:0]       cp_q [3][4];
	logic signed [CW-1:0]       cp_new [3][4];
	logic signed [CW-1:0]       w_q [4];
	logic [bst_pkg::T_BITS-1:0] t_q;
	logic [SW-1:0]              racc_q;
	logic [SW:0]                racc_sum;
	logic signed [CW-1:0]       opa;
	logic signed [CW-1:0]       opb;
	logic signed [DW-1:0]       diff;
	logic signed [bst_pkg::T_BITS:0] t_s;
	logic signed [PW-1:0]       prod_c;
	logic signed [PW-1:0]       prod_s1;
	logic signed [CW-1:0]       a_s1;
	logic signed [PW-1:0]       sum_w;
	logic signed [CW-1:0]       lerp_res;
	logic                       ovf;
	logic [C-1:0]               sat;
	logic [C-1:0]               res_q [3];
	logic [OUT_TDW-1:0]         out_data_q;
	logic                       out_last_q;

	always_comb begin
		logic signed [CW-1:0] s;
		logic signed [CW-1:0] e;
		logic signed [CW-1:0] h0;
		logic signed [CW-1:0] h1;
		for (int a = 0; a < 3; a++) begin
			s  = CW'($signed(in_data[a*C +: C]));
			e  = CW'($signed(in_data[(3+a)*C +: C]));
			h0 = CW'($signed(in_data[(6+a)*C +: C]));
			h1 = CW'($signed(in_data[(9+a)*C +: C]));
			cp_new[a][0] = s;
			cp_new[a][3] = e;
			if (kind == bst_pkg::KIND_QUAD) begin
				cp_new[a][1] = h0;
				cp_new[a][2] = e;
			end else begin
				cp_new[a][1] = s + h0;
				cp_new[a][2] = e + h1;
			end
		end
	end

	// rotate rows so the axis in work always sits in row 0
	always_ff @(posedge clk) begin
		if (cmd.load_cp) begin
			cp_q <= cp_new;
		end else if (cmd.axis_done) begin
			cp_q[0] <= cp_q[1];
			cp_q[1] <= cp_q[2];
			cp_q[2] <= cp_q[0];
		end
	end

	assign racc_sum = {1'b0, racc_q} + {1'b0, r};

	always_ff @(posedge clk) begin
		if (cmd.t_init) begin
			t_q    <= '0;
			racc_q <= '0;
		end else if (cmd.t_adv) begin
			if (racc_sum >= {1'b0, n_eff}) begin
				racc_q <= SW'(racc_sum - {1'b0, n_eff});
				t_q    <= t_q + q + 1'b1;
			end else begin
				racc_q <= SW'(racc_sum);
				t_q    <= t_q + q;
			end
		end
	end

	always_comb begin
		case (cmd.k)
			2'd1: begin
				opa = w_q[1];
				opb = w_q[2];
			end
			2'd2: begin
				opa = w_q[2];
				opb = w_q[3];
			end
			default: begin
				opa = w_q[0];
				opb = w_q[1];
			end
		endcase
	end

	assign diff     = DW'(opb) - DW'(opa);
	assign t_s      = $signed({1'b0, t_q});
	assign prod_c   = diff * t_s;
	assign sum_w    = PW'(a_s1) + (prod_s1 >>> bst_pkg::T_FRAC);
	assign lerp_res = sum_w[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= prod_c;
			a_s1    <= opa;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_w) begin
			w_q <= cp_q[0];
		end else if (cmd.add) begin
			case (cmd.k)
				2'd1:    w_q[1] <= lerp_res;
				2'd2:    w_q[2] <= lerp_res;
				default: w_q[0] <= lerp_res;
			endcase
		end
	end

	assign ovf = (w_q[0][CW-1] != w_q[0][C-1]);
	assign sat = !ovf ? w_q[0][C-1:0]
	                  : (w_q[0][CW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}});

	always_ff @(posedge clk) begin
		if (cmd.axis_done) begin
			res_q[2] <= sat;
			res_q[1] <= res_q[2];
			res_q[0] <= res_q[1];
		end
		if (cmd.out_load) begin
			out_data_q <= OUT_TDW'({res_q[2], res_q[1], res_q[0]});
			out_last_q <= cmd.last;
		end
	end

	assign sts.t_one = (t_q == bst_pkg::T_ONE);
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== src/bezier_segment_tessellator.sv =====
// Bezier segment tessellator top level: configuration registers, controller,
// datapath and step divider. Depends on bst_pkg and the defines header.
//
// Each accepted segment yields N points at t = i/N, i = 1..N, by de Casteljau
// interpolation on one shared multiply-add unit that takes a multiply state
// and an add state per interpolation. The result side can stall a segment,
// and the serial t divider runs before its first point; the next segment is
// taken once the last point sits in the output register. N is the step count,
// 0 read as 1 and clamped to MAX_STEPS.
`include "bezier_segment_tessellator_defines.svh"

module bezier_segment_tessellator #(
	parameter int MAX_STEPS  = 64,
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bst_pkg::STEPS_W-1:0]   cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// start_x, start_y, start_z, end_x, end_y, end_z, handle0_x, handle0_y,
	// handle0_z, handle1_x, handle1_y, handle1_z, zero fill
	input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// point_x, point_y, point_z, zero fill
	output logic [((3*COORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
	output logic                          m_axis_tlast
);

	localparam int SW      = $clog2(MAX_STEPS + 1);
	localparam int EXT_W   = (SW > bst_pkg::STEPS_W) ? SW : bst_pkg::STEPS_W;
	localparam int IN_TDW  = ((12*COORD_BITS+7)/8)*8;
	localparam int OUT_TDW = ((3*COORD_BITS+7)/8)*8;

	logic                         kind_q;
	logic [bst_pkg::STEPS_W-1:0]  steps_q;
	logic [SW-1:0]                n_eff;
	bst_pkg::bst_cmd_t            cmd;
	bst_pkg::bst_sts_t            sts;
	logic                         div_done;
	logic [bst_pkg::T_BITS-1:0]   div_q;
	logic [SW-1:0]                div_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= bst_pkg::KIND_CUBIC;
			steps_q <= 7'd24;
		end else if (cfg_we) begin
			case (cfg_index)
				bst_pkg::REG_CURVE_KIND: kind_q  <= cfg_wdata[0];
				bst_pkg::REG_STEPS:      steps_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (steps_q == '0) begin
			n_eff = SW'(1);
		end else if (EXT_W'(steps_q) > EXT_W'(MAX_STEPS)) begin
			n_eff = SW'(MAX_STEPS);
		end else begin
			n_eff = SW'(steps_q);
		end
	end

	bst_ctrl #(
		.SW(SW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.kind     (kind_q),
		.n_eff    (n_eff),
		.div_done (div_done),
		.cmd      (cmd)
	);

	bst_div #(
		.SW(SW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.n     (n_eff),
		.done  (div_done),
		.q     (div_q),
		.r     (div_r)
	);

	bst_dp #(
		.C      (COORD_BITS),
		.SW     (SW),
		.IN_TDW (IN_TDW),
		.OUT_TDW(OUT_TDW)
	) u_dp (
		.clk     (clk),
		.in_data (s_axis_tdata),
		.kind    (kind_q),
		.n_eff   (n_eff),
		.q       (div_q),
		.r       (div_r),
		.cmd     (cmd),
		.sts     (sts),
		.out_data(m_axis_tdata),
		.out_last(m_axis_tlast)
	);

	`BST_ASSERT_SAME(a_last_at_t_one, cmd.out_load, cmd.last == sts.t_one, "last point not at t one")
	`BST_ASSERT_SAME(a_no_overwrite, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten")
	`BST_ASSERT_NEXT(a_one_segment, s_axis_tvalid && s_axis_tready, !s_axis_tready, "segment taken while busy")

endmodule
